[rtl/bhfl_pkg.sv]
// ----------------------------------------------------------------------------
// bhfl_pkg
// Types and constants shared by the bump heap allocator modules.
// ----------------------------------------------------------------------------
package bhfl_pkg;

	localparam int unsigned ADDR_W = 64;
	localparam int unsigned SIZE_W = 33;
	localparam int unsigned RSIZE_W = 34;
	localparam int unsigned HSIZE_W = 41;
	localparam int unsigned ALIGN_W = 6;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 64'h0000_0600_0000_0000;
	localparam logic [HSIZE_W-1:0] HEAP_SIZE_RST = 41'h001_0000_0000;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUMP_START = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OOM = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADADDR = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd5;

	typedef struct packed {
		logic kind;
		logic [SIZE_W-1:0] block_size;
		logic [ALIGN_W-1:0] align_log2;
		logic [ADDR_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0] granted_address;
		logic reused;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_MOVE_RD,
		S_MOVE_WR,
		S_BUMP1,
		S_BUMP2,
		S_FREE1,
		S_FREE2,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic set_zero;
		logic idx_clr;
		logic idx_inc;
		logic rd_scan;
		logic rd_next;
		logic wr_move;
		logic take_hit;
		logic dec_count;
		logic bump1;
		logic bump2;
		logic free1;
		logic free2;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic size_zero;
		logic is_free;
		logic scan_end;
		logic hit;
		logic move_end;
	} sts_t;

endpackage

[rtl/bhfl_ctrl.sv]
// ----------------------------------------------------------------------------
// bhfl_ctrl
// Sequencer: walks each request through search, compaction, placement or
// release, and owns the result valid flag.
// ----------------------------------------------------------------------------
module bhfl_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  bhfl_pkg::sts_t sts,
	output bhfl_pkg::cmd_t cmd
);

	bhfl_pkg::state_t state_q, state_nxt;
	logic rsp_valid_q;
	logic slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhfl_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bhfl_pkg::S_IDLE: if (req_valid) state_nxt = bhfl_pkg::S_CHECK;
			bhfl_pkg::S_CHECK: begin
				if (sts.size_zero) state_nxt = bhfl_pkg::S_DONE;
				else if (sts.is_free) state_nxt = bhfl_pkg::S_FREE1;
				else state_nxt = bhfl_pkg::S_SCAN_RD;
			end
			bhfl_pkg::S_SCAN_RD: begin
				if (sts.scan_end) state_nxt = bhfl_pkg::S_BUMP1;
				else state_nxt = bhfl_pkg::S_SCAN_CHK;
			end
			bhfl_pkg::S_SCAN_CHK: begin
				if (sts.hit) state_nxt = bhfl_pkg::S_MOVE_RD;
				else state_nxt = bhfl_pkg::S_SCAN_RD;
			end
			bhfl_pkg::S_MOVE_RD: begin
				if (sts.move_end) state_nxt = bhfl_pkg::S_DONE;
				else state_nxt = bhfl_pkg::S_MOVE_WR;
			end
			bhfl_pkg::S_MOVE_WR: state_nxt = bhfl_pkg::S_MOVE_RD;
			bhfl_pkg::S_BUMP1: state_nxt = bhfl_pkg::S_BUMP2;
			bhfl_pkg::S_BUMP2: state_nxt = bhfl_pkg::S_DONE;
			bhfl_pkg::S_FREE1: state_nxt = bhfl_pkg::S_FREE2;
			bhfl_pkg::S_FREE2: state_nxt = bhfl_pkg::S_DONE;
			bhfl_pkg::S_DONE: if (slot_free) state_nxt = bhfl_pkg::S_IDLE;
			default: state_nxt = bhfl_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			bhfl_pkg::S_IDLE: begin
				req_ready = 1'b1;
				cmd.load = req_valid;
			end
			bhfl_pkg::S_CHECK: begin
				cmd.set_zero = sts.size_zero;
				cmd.idx_clr = 1'b1;
			end
			bhfl_pkg::S_SCAN_RD: cmd.rd_scan = !sts.scan_end;
			bhfl_pkg::S_SCAN_CHK: begin
				cmd.take_hit = sts.hit;
				cmd.idx_inc = !sts.hit;
			end
			bhfl_pkg::S_MOVE_RD: begin
				cmd.dec_count = sts.move_end;
				cmd.rd_next = !sts.move_end;
			end
			bhfl_pkg::S_MOVE_WR: begin
				cmd.wr_move = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			bhfl_pkg::S_BUMP1: cmd.bump1 = 1'b1;
			bhfl_pkg::S_BUMP2: cmd.bump2 = 1'b1;
			bhfl_pkg::S_FREE1: cmd.free1 = 1'b1;
			bhfl_pkg::S_FREE2: cmd.free2 = 1'b1;
			bhfl_pkg::S_DONE: cmd.push = slot_free;
			default: cmd = '0;
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[rtl/bhfl_dp.sv]
// ----------------------------------------------------------------------------
// bhfl_dp
// Datapath: configuration registers, bump pointer, free table memory,
// placement and range arithmetic, result registers.
// ----------------------------------------------------------------------------
module bhfl_dp #(
	parameter int unsigned FREE_ENTRIES = 64,
	parameter int unsigned MIN_ALIGN = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  bhfl_pkg::req_t req,
	output bhfl_pkg::rsp_t rsp,
	input  logic cfg_we,
	input  logic [bhfl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bhfl_pkg::ADDR_W-1:0] cfg_wdata,
	input  bhfl_pkg::cmd_t cmd,
	output bhfl_pkg::sts_t sts
);

	localparam int unsigned CW = $clog2(FREE_ENTRIES + 1);
	localparam int unsigned IW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
	localparam int unsigned AW = bhfl_pkg::ADDR_W;
	localparam int unsigned RW = bhfl_pkg::RSIZE_W;
	localparam int unsigned EW = RW + AW;
	localparam logic [AW-1:0] MIN_MASK = AW'(MIN_ALIGN - 1);
	localparam logic [CW-1:0] ENTRIES = CW'(FREE_ENTRIES);

	logic [AW-1:0] base_q;
	logic [bhfl_pkg::HSIZE_W-1:0] hsize_q;
	logic [AW-1:0] bump_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;

	logic kind_q;
	logic [RW-1:0] size_q;
	logic [AW-1:0] mask_q;
	logic [AW-1:0] addr_q;

	logic [EW-1:0] mem [FREE_ENTRIES];
	logic [EW-1:0] rdata_q;
	logic mem_re, mem_we;
	logic [IW-1:0] raddr, waddr;
	logic [EW-1:0] wdata;

	logic [AW-1:0] place_s1;
	logic carry_s1;
	logic lt_s1;
	logic [AW:0] sum_s1;
	logic [AW:0] limit_s1;

	logic [bhfl_pkg::STATUS_W-1:0] st_q;
	logic [AW-1:0] ga_q;
	logic ru_q;
	bhfl_pkg::rsp_t rsp_q;

	logic [RW-1:0] rsize;
	logic [AW-1:0] amask;
	logic [AW:0] tsum;
	logic [AW:0] endv;
	logic [CW:0] idx_p1;

	assign rsize = (RW'(req.block_size) + RW'(MIN_ALIGN - 1)) & ~RW'(MIN_ALIGN - 1);
	assign amask = mask_q | MIN_MASK;
	assign tsum = {1'b0, bump_q} + {1'b0, amask};
	assign endv = {1'b0, place_s1} + (AW + 1)'(size_q);
	assign idx_p1 = {1'b0, idx_q} + (CW + 1)'(1);

	assign sts.size_zero = (size_q == '0);
	assign sts.is_free = kind_q;
	assign sts.scan_end = (idx_q >= count_q);
	assign sts.move_end = (idx_p1 >= {1'b0, count_q});
	assign sts.hit = (rdata_q[EW-1:AW] == size_q) && ((rdata_q[AW-1:0] & mask_q) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= bhfl_pkg::HEAP_BASE_RST;
			hsize_q <= bhfl_pkg::HEAP_SIZE_RST;
			bump_q <= bhfl_pkg::HEAP_BASE_RST;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bhfl_pkg::REG_HEAP_BASE: base_q <= cfg_wdata;
					bhfl_pkg::REG_HEAP_SIZE: hsize_q <= cfg_wdata[bhfl_pkg::HSIZE_W-1:0];
					bhfl_pkg::REG_BUMP_START: bump_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.bump2 && !carry_s1 && !endv[AW] && !(endv > limit_s1)) begin
				bump_q <= endv[AW-1:0];
			end
			if (cmd.dec_count) begin
				count_q <= count_q - CW'(1);
			end else if (cmd.free2 && !lt_s1 && !(sum_s1 > limit_s1) && count_q < ENTRIES) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req.kind;
			size_q <= rsize;
			mask_q <= (AW'(1) << req.align_log2) - AW'(1);
			addr_q <= req.block_address;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.bump1) begin
			place_s1 <= tsum[AW-1:0] & ~amask;
			carry_s1 <= tsum[AW];
		end
		if (cmd.free1) begin
			lt_s1 <= addr_q < base_q;
			sum_s1 <= {1'b0, addr_q} + (AW + 1)'(size_q);
		end
		if (cmd.bump1 || cmd.free1) begin
			limit_s1 <= {1'b0, base_q} + (AW + 1)'(hsize_q);
		end
		if (cmd.set_zero) begin
			st_q <= bhfl_pkg::ST_ZERO;
			ga_q <= '0;
			ru_q <= 1'b0;
		end
		if (cmd.take_hit) begin
			st_q <= bhfl_pkg::ST_OK;
			ga_q <= rdata_q[AW-1:0];
			ru_q <= 1'b1;
		end
		if (cmd.bump2) begin
			ru_q <= 1'b0;
			if (carry_s1 || endv[AW]) begin
				st_q <= bhfl_pkg::ST_OVERFLOW;
				ga_q <= '0;
			end else if (endv > limit_s1) begin
				st_q <= bhfl_pkg::ST_OOM;
				ga_q <= '0;
			end else begin
				st_q <= bhfl_pkg::ST_OK;
				ga_q <= place_s1;
			end
		end
		if (cmd.free2) begin
			ru_q <= 1'b0;
			ga_q <= '0;
			if (lt_s1 || sum_s1 > limit_s1) begin
				st_q <= bhfl_pkg::ST_BADADDR;
			end else if (count_q >= ENTRIES) begin
				st_q <= bhfl_pkg::ST_FULL;
			end else begin
				st_q <= bhfl_pkg::ST_OK;
			end
		end
		if (cmd.push) begin
			rsp_q.status <= st_q;
			rsp_q.granted_address <= ga_q;
			rsp_q.reused <= ru_q;
		end
	end

	always_comb begin
		mem_re = cmd.rd_scan || cmd.rd_next;
		raddr = cmd.rd_next ? idx_p1[IW-1:0] : idx_q[IW-1:0];
		mem_we = cmd.wr_move ||
			(cmd.free2 && !lt_s1 && !(sum_s1 > limit_s1) && count_q < ENTRIES);
		waddr = cmd.wr_move ? idx_q[IW-1:0] : count_q[IW-1:0];
		wdata = cmd.wr_move ? rdata_q : {size_q, addr_q};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rsp = rsp_q;

endmodule

[rtl/bump_heap_with_size_free_list.sv]
// ----------------------------------------------------------------------------
// bump_heap_with_size_free_list
// Heap allocator: bump pointer placement with an exact-size free table.
// ----------------------------------------------------------------------------
// Requests enter on req (valid/ready): kind 0 allocates block_size bytes at
// 2**align_log2 alignment, kind 1 returns a block at block_address. Every
// request yields one result on rsp (valid/ready): status, granted address and
// a reused flag when the block came from the free table.
// One request is worked at a time. A free checks the block range, then
// appends the block to the table if it is in range and there is room. An
// allocation scans the free table oldest first, reading then checking each
// entry (one memory read port, registered), then either compacts the table
// by moving later entries down or aligns, checks and bumps the pointer.
// The result register parts the two sides: a new request is taken while a
// result waits; a request whose result is ready holds until the receiver
// takes the earlier one.
// Reset empties the free table and loads the bump pointer and the heap
// registers with their defaults; no clearing pass is needed.
// Configuration (cfg_we/cfg_index/cfg_wdata) must be written only while idle;
// the block does not enforce this. Writing bump_start loads the bump pointer.
// ----------------------------------------------------------------------------
module bump_heap_with_size_free_list #(
	parameter int unsigned FREE_ENTRIES = 64,
	parameter int unsigned MIN_ALIGN = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  bhfl_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output bhfl_pkg::rsp_t rsp,
	input  logic cfg_we,
	input  logic [bhfl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bhfl_pkg::ADDR_W-1:0] cfg_wdata
);

	bhfl_pkg::cmd_t cmd;
	bhfl_pkg::sts_t sts;

	bhfl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.sts(sts),
		.cmd(cmd)
	);

	bhfl_dp #(
		.FREE_ENTRIES(FREE_ENTRIES),
		.MIN_ALIGN(MIN_ALIGN)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd),
		.sts(sts)
	);

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

	a_err_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != bhfl_pkg::ST_OK |-> rsp.granted_address == '0)
		else $error("failed request carries an address");

	a_reuse_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.reused |-> rsp.status == bhfl_pkg::ST_OK)
		else $error("reused flag on a failed request");

	a_push_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !rsp_valid || rsp_ready)
		else $error("result overwritten before it was taken");
`endif

endmodule
